FILE: hw/rtl/pmu_pkg.sv
// Shared constants for the pheromone matrix update engine: codes, register indexes, widths.
package pmu_pkg;

  // Command codes carried in the request
  localparam logic [1:0] CMD_INIT     = 2'd0;
  localparam logic [1:0] CMD_EVAP     = 2'd1;
  localparam logic [1:0] CMD_PRESERVE = 2'd2;
  localparam logic [1:0] CMD_READ     = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_CUST_CNT      = 3'd0;
  localparam logic [2:0] REG_INITIAL_TRAIL = 3'd1;
  localparam logic [2:0] REG_RESET_TRAIL   = 3'd2;
  localparam logic [2:0] REG_EVAP_RATE     = 3'd3;
  localparam logic [2:0] REG_PRESERVATION  = 3'd4;
  localparam logic [2:0] REG_AVAIL_MASK    = 3'd5;

  // Field and port widths
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned NODE_W     = 6;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 63;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned RATE_W     = 16;
  localparam int unsigned MASK_W     = 63;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 40;

  // Q0.16 unity, used to form (1 - rate) factors
  localparam logic [RATE_W:0] RATE_ONE = 17'h10000;

endpackage

FILE: hw/rtl/pheromone_matrix_update_engine.sv
// Pheromone matrix update engine: symmetric trail matrix with init, evaporate, preserve, read.
//
// One request is taken at a time; s_axis_tready is high only while the sequencer is idle.
// The matrix is held once, lower triangle only, in a one-write one-read memory, and every
// update goes through a single trail-by-17-bit multiplier. With N active nodes
// (customer count + 1, at most MAX_NODES) a sweep visits N(N+1)/2 entries: init writes one
// entry per cycle, evaporate reads, multiplies and writes each entry, and preserve reads,
// multiplies and writes each blended entry and reads and writes each entry reset to the
// baseline, after first forming the baseline term. A read does a memory read, then a
// result select. Every request is accepted in idle and ends by loading the result
// register, which frees up once the previous result is taken. The memory is not cleared
// after reset; run init before reading or updating.
module pheromone_matrix_update_engine #(
  parameter int unsigned MAX_NODES   = 64,
  parameter int unsigned TRAIL_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Request stream; tdata fields from bit 0: command[1:0], row[7:2], col[13:8]
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [pmu_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // Result stream; tdata fields from bit 0: value[31:0], done_command[33:32]
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [pmu_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // Configuration write port
  input  logic                              cfg_we_i,
  input  logic [pmu_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pmu_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned NW       = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned CW       = (NW > pmu_pkg::NODE_W) ? NW + 1 : pmu_pkg::NODE_W + 1;
  localparam int unsigned AW       = 2 * NW;
  localparam int unsigned DEPTH    = 1 << AW;
  localparam int unsigned TW       = TRAIL_WIDTH;
  localparam int unsigned PW       = TW + pmu_pkg::RATE_W + 1;
  localparam int unsigned RW       = pmu_pkg::RATE_W;

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_BASE  = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_WR    = 3'd4;
  localparam logic [2:0] S_RDOUT = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  // Configuration registers
  logic [pmu_pkg::NODE_W-1:0]  cust_cnt_q;
  logic [pmu_pkg::VALUE_W-1:0] init_trail_q;
  logic [pmu_pkg::VALUE_W-1:0] reset_trail_q;
  logic [RW-1:0]               evap_rate_q;
  logic [RW-1:0]               pres_q;
  logic [pmu_pkg::MASK_W-1:0]  avail_mask_q;

  // Sequencer and datapath registers
  logic [2:0]                  state_q, state_d;
  logic [1:0]                  cmd_q;
  logic [pmu_pkg::NODE_W-1:0]  row_q, col_q;
  logic [NW-1:0]               i_q, i_d, j_q, j_d;
  logic [TW-1:0]               base_q;
  logic [TW-1:0]               scaled_q;
  logic [TW-1:0]               rd_data_q;
  logic [pmu_pkg::VALUE_W-1:0] res_value_q;
  logic                        out_valid_q;
  logic [pmu_pkg::VALUE_W-1:0] out_value_q;
  logic [1:0]                  out_cmd_q;

  logic [TW-1:0] mem [DEPTH];

  logic                  in_accept, out_accept, fin_load;
  logic [NW-1:0]         last_row;
  logic                  last_entry;
  logic                  blend;
  logic [NW-1:0]         rd_row, rd_col, rd_hi, rd_lo;
  logic                  rd_in_range;
  logic [AW-1:0]         rd_addr;
  logic                  rd_en, wr_en;
  logic [TW-1:0]         wr_data;
  logic [TW-1:0]         mul_a;
  logic [RW:0]           mul_b;
  logic [PW-1:0]         prod;
  logic [TW:0]           sum;
  logic [TW-1:0]         t0;

  // Customer availability for one node index; the depot and nodes past 63 never count
  function automatic logic node_avail(input logic [NW-1:0] node,
                                      input logic [pmu_pkg::MASK_W-1:0] mask);
    logic [8:0]  node_w;
    logic [63:0] mask_w;
    node_w = 9'(node);
    mask_w = {1'b0, mask};
    return (node_w != 9'd0) && (node_w <= 9'd63) && mask_w[6'(node_w - 9'd1)];
  endfunction

  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_accept    = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign fin_load      = (state_q == S_FIN) && (!out_valid_q || m_axis_tready);

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cust_cnt_q    <= 6'd63;
      init_trail_q  <= 32'd16777216;
      reset_trail_q <= 32'd16777216;
      evap_rate_q   <= 16'd6554;
      pres_q        <= 16'd32768;
      avail_mask_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        pmu_pkg::REG_CUST_CNT:       cust_cnt_q    <= cfg_data_i[pmu_pkg::NODE_W-1:0];
        pmu_pkg::REG_INITIAL_TRAIL:  init_trail_q  <= cfg_data_i[pmu_pkg::VALUE_W-1:0];
        pmu_pkg::REG_RESET_TRAIL:    reset_trail_q <= cfg_data_i[pmu_pkg::VALUE_W-1:0];
        pmu_pkg::REG_EVAP_RATE:      evap_rate_q   <= cfg_data_i[RW-1:0];
        pmu_pkg::REG_PRESERVATION:   pres_q        <= cfg_data_i[RW-1:0];
        pmu_pkg::REG_AVAIL_MASK:     avail_mask_q  <= cfg_data_i[pmu_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Last active row: customer count clamped to MAX_NODES - 1
  always_comb begin
    logic [CW-1:0] cc_w;
    logic [CW-1:0] max_w;
    cc_w     = CW'(cust_cnt_q);
    max_w    = CW'(MAX_NODES - 1);
    last_row = NW'((cc_w > max_w) ? max_w : cc_w);
  end

  assign last_entry = (i_q == last_row) && (j_q == i_q);
  assign t0         = TW'(reset_trail_q);

  // Blend rule for the current (i, j) with j <= i
  always_comb begin
    logic ia, ja;
    ia    = node_avail(i_q, avail_mask_q);
    ja    = node_avail(j_q, avail_mask_q);
    blend = (ia && ja) || ((i_q == '0) && ja) || ((j_q == '0) && ia);
  end

  // Read address: sweep position, or the requested entry folded into the lower triangle
  always_comb begin
    rd_row      = NW'(row_q);
    rd_col      = NW'(col_q);
    rd_in_range = (CW'(row_q) < CW'(MAX_NODES)) && (CW'(col_q) < CW'(MAX_NODES));
    rd_hi       = (rd_row > rd_col) ? rd_row : rd_col;
    rd_lo       = (rd_row > rd_col) ? rd_col : rd_row;
    rd_addr     = (cmd_q == pmu_pkg::CMD_READ) ? {rd_hi, rd_lo} : {i_q, j_q};
  end

  // Shared multiplier: baseline term in S_BASE, entry scaling in S_MUL
  always_comb begin
    mul_a = (state_q == S_BASE) ? t0 : rd_data_q;
    if (state_q == S_BASE) begin
      mul_b = {1'b0, pres_q};
    end else if (cmd_q == pmu_pkg::CMD_EVAP) begin
      mul_b = pmu_pkg::RATE_ONE - {1'b0, evap_rate_q};
    end else begin
      mul_b = pmu_pkg::RATE_ONE - {1'b0, pres_q};
    end
    prod = PW'(mul_a) * PW'(mul_b);
  end

  // Write data per command, with saturating blend
  always_comb begin
    sum = {1'b0, scaled_q} + {1'b0, base_q};
    case (cmd_q)
      pmu_pkg::CMD_INIT: wr_data = TW'(init_trail_q);
      pmu_pkg::CMD_EVAP: wr_data = scaled_q;
      default:           wr_data = blend ? (sum[TW] ? '1 : sum[TW-1:0]) : t0;
    endcase
  end

  assign rd_en = (state_q == S_RD);
  assign wr_en = (state_q == S_WR);

  // Matrix memory, lower triangle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[{i_q, j_q}] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // Sequencer next state and sweep counters
  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          i_d = '0;
          j_d = '0;
          unique case (s_axis_tdata[1:0])
            pmu_pkg::CMD_INIT:     state_d = S_WR;
            pmu_pkg::CMD_PRESERVE: state_d = S_BASE;
            default:               state_d = S_RD;
          endcase
        end
      end
      S_BASE: state_d = S_RD;
      S_RD: begin
        if (cmd_q == pmu_pkg::CMD_READ) begin
          state_d = S_RDOUT;
        end else if ((cmd_q == pmu_pkg::CMD_PRESERVE) && !blend) begin
          state_d = S_WR;
        end else begin
          state_d = S_MUL;
        end
      end
      S_MUL: state_d = S_WR;
      S_WR: begin
        if (last_entry) begin
          state_d = S_FIN;
        end else begin
          if (j_q == i_q) begin
            i_d = i_q + 1'b1;
            j_d = '0;
          end else begin
            j_d = j_q + 1'b1;
          end
          state_d = (cmd_q == pmu_pkg::CMD_INIT) ? S_WR : S_RD;
        end
      end
      S_RDOUT: state_d = S_FIN;
      S_FIN: begin
        if (fin_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
    end
  end

  // Request capture and datapath registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q       <= s_axis_tdata[1:0];
      row_q       <= s_axis_tdata[7:2];
      col_q       <= s_axis_tdata[13:8];
      res_value_q <= '0;
    end
    if (state_q == S_BASE) begin
      base_q <= prod[TW+RW-1:RW];
    end
    if (state_q == S_MUL) begin
      scaled_q <= prod[TW+RW-1:RW];
    end
    if (state_q == S_RDOUT) begin
      res_value_q <= rd_in_range ? pmu_pkg::VALUE_W'(rd_data_q) : '0;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_load) begin
      out_valid_q <= 1'b1;
    end else if (out_accept) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_load) begin
      out_value_q <= res_value_q;
      out_cmd_q   <= cmd_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_cmd_q, out_value_q};

  // Sweep column never passes the row
  a_col_le_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    j_q <= i_q)
    else $error("sweep column ran past row");

  // Sweep row stays inside the active region while updating
  a_row_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WR || state_q == S_MUL) |-> (i_q <= last_row))
    else $error("sweep row outside active region");

  // An accepted request leaves idle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q != S_IDLE))
    else $error("request accepted but sequencer stayed idle");

  // Finishing a request presents a result and returns to idle
  a_fin_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_load |=> (out_valid_q && state_q == S_IDLE))
    else $error("finished request did not present a result");

endmodule
